>>> hdl/wsp_pkg.sv
// ----------------------------------------------------------------------------
// wsp_pkg
// Shared types and constants for the WAV stream parser and level meter.
// ----------------------------------------------------------------------------
package wsp_pkg;

    localparam int BUF_BYTES = 2048;
    localparam int BL_W      = $clog2(BUF_BYTES + 1);
    localparam int CNT_W     = $clog2(BUF_BYTES / 2 + 1);
    localparam int SUM_W     = CNT_W + 16;
    localparam int DVS_W     = 16;
    localparam int QW        = (SUM_W > 23) ? SUM_W : 23;
    localparam int ITER_W    = $clog2(QW + 1);

    localparam int FQ_DEPTH  = 4;
    localparam int FQ_PTR_W  = $clog2(FQ_DEPTH);
    localparam int FQ_CNT_W  = $clog2(FQ_DEPTH + 1);

    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;
    localparam logic [31:0] FMT_BODY = 32'd16;
    localparam logic [6:0]  LEVEL_MAX = 7'd100;

    localparam logic [2:0] ST_SAMPLE   = 3'd0;
    localparam logic [2:0] ST_BAD_RIFF = 3'd1;
    localparam logic [2:0] ST_SHORT_FMT = 3'd2;
    localparam logic [2:0] ST_BAD_FMT  = 3'd3;
    localparam logic [2:0] ST_ODD_BYTE = 3'd4;

    localparam logic CFG_NOISE = 1'b0;
    localparam logic CFG_FULL  = 1'b1;

    localparam logic [15:0] NOISE_RESET = 16'd180;
    localparam logic [15:0] FULL_RESET  = 16'd5200;

    // One request from the parser to the meter.
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] sample;
        logic        right;
        logic        stereo;
        logic [31:0] rate;
        logic        lv;
        logic        last;
        logic        first;
        logic        acc;
    } t_rec;

endpackage

>>> hdl/wsp_front.sv
// ----------------------------------------------------------------------------
// wsp_front
// Byte parser: RIFF header check, chunk walk, fmt decode, sample assembly.
// ----------------------------------------------------------------------------
module wsp_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_take,
    input  logic [7:0]    i_stream_byte,
    input  logic          i_stream_start,
    output logic          o_push,
    output wsp_pkg::t_rec o_rec
);
    import wsp_pkg::*;

    localparam logic [2:0] PH_RIFF = 3'd0;
    localparam logic [2:0] PH_CHDR = 3'd1;
    localparam logic [2:0] PH_FMT  = 3'd2;
    localparam logic [2:0] PH_SKIP = 3'd3;
    localparam logic [2:0] PH_PAD  = 3'd4;
    localparam logic [2:0] PH_DATA = 3'd5;
    localparam logic [2:0] PH_IDLE = 3'd6;

    logic [2:0]      r_phase, n_phase;
    logic [3:0]      r_cnt, n_cnt;
    logic [31:0]     r_tag, n_tag, r_size, n_size, r_skip, n_skip;
    logic            r_pad, n_pad;
    logic [15:0]     r_fmt, n_fmt, r_chan, n_chan, r_bits, n_bits;
    logic [31:0]     r_rate, n_rate, r_dleft, n_dleft;
    logic [BL_W-1:0] r_bleft, n_bleft;
    logic [7:0]      r_low, n_low;
    logic            r_bad, n_bad, r_odd, n_odd, r_bpar, n_bpar, r_first, n_first;

    logic [3:0]      n;
    logic [BL_W-1:0] bsz;
    logic [7:0]      b;

    assign b = i_stream_byte;

    always_comb begin
        n_phase = r_phase; n_cnt = r_cnt; n_tag = r_tag; n_size = r_size;
        n_skip = r_skip; n_pad = r_pad; n_fmt = r_fmt; n_chan = r_chan;
        n_bits = r_bits; n_rate = r_rate; n_dleft = r_dleft; n_bleft = r_bleft;
        n_low = r_low; n_bad = r_bad; n_odd = r_odd; n_bpar = r_bpar;
        n_first = r_first;
        o_push = 1'b0;
        o_rec = '0;
        n = '0;
        bsz = '0;
        if (i_take) begin
            if (i_stream_start) begin
                n_phase = PH_RIFF; n_cnt = '0; n_tag = '0; n_size = '0;
                n_skip = '0; n_pad = 1'b0; n_fmt = '0; n_chan = '0;
                n_bits = '0; n_rate = '0; n_dleft = '0; n_bleft = '0;
                n_low = '0; n_bad = 1'b0; n_odd = 1'b0; n_bpar = 1'b0;
                n_first = 1'b0;
            end
            n = n_cnt;
            unique case (n_phase)
                PH_RIFF: begin
                    if (n < 4'd4 && b != TAG_RIFF[{n[1:0], 3'b000} +: 8]) n_bad = 1'b1;
                    if (n >= 4'd8 && b != TAG_WAVE[{n[1:0], 3'b000} +: 8]) n_bad = 1'b1;
                    n_cnt = n + 4'd1;
                    if (n == 4'd11) begin
                        if (n_bad) begin
                            n_phase = PH_IDLE;
                            o_push = 1'b1;
                            o_rec.status = ST_BAD_RIFF;
                        end else begin
                            n_phase = PH_CHDR;
                            n_cnt = '0;
                        end
                    end
                end
                PH_CHDR: begin
                    if (n < 4'd4) begin
                        if (n == 4'd0) n_tag = '0;
                        n_tag[{n[1:0], 3'b000} +: 8] = b;
                    end else begin
                        if (n == 4'd4) n_size = '0;
                        n_size[{n[1:0], 3'b000} +: 8] = b;
                    end
                    n_cnt = n + 4'd1;
                    if (n == 4'd7) begin
                        n_cnt = '0;
                        n_pad = n_size[0];
                        if (n_tag == TAG_FMT) begin
                            if (n_size < FMT_BODY) begin
                                n_phase = PH_IDLE;
                                o_push = 1'b1;
                                o_rec.status = ST_SHORT_FMT;
                            end else begin
                                n_skip = n_size - FMT_BODY;
                                n_phase = PH_FMT;
                            end
                        end else if (n_tag == TAG_DATA && n_size != '0) begin
                            if (n_fmt != 16'd1 || n_bits != 16'd16 ||
                                (n_chan != 16'd1 && n_chan != 16'd2) || n_rate == '0) begin
                                n_phase = PH_IDLE;
                                o_push = 1'b1;
                                o_rec.status = ST_BAD_FMT;
                            end else begin
                                n_dleft = n_size;
                                n_bleft = '0;
                                n_odd = 1'b0;
                                n_phase = PH_DATA;
                            end
                        end else begin
                            // empty data chunks are walked past like unknown ones
                            n_skip = (n_tag == TAG_DATA) ? 32'd0 : n_size;
                            n_phase = (n_skip != '0) ? PH_SKIP : (n_pad ? PH_PAD : PH_CHDR);
                        end
                    end
                end
                PH_FMT: begin
                    if (n < 4'd2) n_fmt[{n[0], 3'b000} +: 8] = b;
                    else if (n < 4'd4) n_chan[{n[0], 3'b000} +: 8] = b;
                    else if (n < 4'd8) n_rate[{n[1:0], 3'b000} +: 8] = b;
                    else if (n >= 4'd14) n_bits[{n[0], 3'b000} +: 8] = b;
                    n_cnt = n + 4'd1;
                    if (n == 4'd15) begin
                        n_cnt = '0;
                        n_phase = (n_skip != '0) ? PH_SKIP : (n_pad ? PH_PAD : PH_CHDR);
                    end
                end
                PH_SKIP: begin
                    n_skip = n_skip - 32'd1;
                    if (n_skip == '0) begin
                        n_cnt = '0;
                        n_phase = n_pad ? PH_PAD : PH_CHDR;
                    end
                end
                PH_PAD: begin
                    n_pad = 1'b0;
                    n_phase = PH_CHDR;
                    n_cnt = '0;
                end
                PH_DATA: begin
                    if (n_dleft < 32'(BUF_BYTES)) bsz = n_dleft[BL_W-1:0];
                    else bsz = BL_W'(BUF_BYTES);
                    bsz[0] = 1'b0;
                    if (n_bleft == '0 && bsz == '0) begin
                        n_phase = PH_IDLE;
                        o_push = 1'b1;
                        o_rec.status = ST_ODD_BYTE;
                    end else begin
                        if (n_bleft == '0) begin
                            n_bleft = bsz;
                            n_bpar = 1'b0;
                            n_first = 1'b1;
                        end
                        n_dleft = n_dleft - 32'd1;
                        n_bleft = n_bleft - BL_W'(1);
                        if (n_bleft[0]) begin
                            n_low = b;
                        end else begin
                            o_push = 1'b1;
                            o_rec.status = ST_SAMPLE;
                            o_rec.sample = {b, n_low};
                            o_rec.stereo = (n_chan == 16'd2);
                            o_rec.right = (n_chan == 16'd2) && n_odd;
                            o_rec.rate = n_rate;
                            o_rec.acc = (n_chan == 16'd1) || !n_bpar;
                            o_rec.first = n_first;
                            o_rec.lv = (n_bleft == '0);
                            o_rec.last = (n_dleft == '0);
                            n_first = 1'b0;
                            n_bpar = !n_bpar;
                            n_odd = !n_odd;
                            if (n_dleft == '0) n_phase = PH_IDLE;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_RIFF; r_cnt <= '0; r_tag <= '0; r_size <= '0;
            r_skip <= '0; r_pad <= 1'b0; r_fmt <= '0; r_chan <= '0;
            r_bits <= '0; r_rate <= '0; r_dleft <= '0; r_bleft <= '0;
            r_low <= '0; r_bad <= 1'b0; r_odd <= 1'b0; r_bpar <= 1'b0;
            r_first <= 1'b0;
        end else begin
            r_phase <= n_phase; r_cnt <= n_cnt; r_tag <= n_tag; r_size <= n_size;
            r_skip <= n_skip; r_pad <= n_pad; r_fmt <= n_fmt; r_chan <= n_chan;
            r_bits <= n_bits; r_rate <= n_rate; r_dleft <= n_dleft; r_bleft <= n_bleft;
            r_low <= n_low; r_bad <= n_bad; r_odd <= n_odd; r_bpar <= n_bpar;
            r_first <= n_first;
        end
    end

endmodule

>>> hdl/wsp_fifo.sv
// ----------------------------------------------------------------------------
// wsp_fifo
// Short request queue between the parser and the level meter.
// ----------------------------------------------------------------------------
module wsp_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  wsp_pkg::t_rec i_wdata,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output wsp_pkg::t_rec o_rdata
);
    import wsp_pkg::*;

    t_rec                r_mem [FQ_DEPTH];
    logic [FQ_PTR_W-1:0] r_wp, r_rp;
    logic [FQ_CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == FQ_CNT_W'(FQ_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + FQ_PTR_W'(1);
            if (i_pop) r_rp <= r_rp + FQ_PTR_W'(1);
            if (i_push && !i_pop) r_cnt <= r_cnt + FQ_CNT_W'(1);
            else if (!i_push && i_pop) r_cnt <= r_cnt - FQ_CNT_W'(1);
        end
    end

endmodule

>>> hdl/wsp_back.sv
// ----------------------------------------------------------------------------
// wsp_back
// Level meter: amplitude sum, serial divider for mean and scale, output stage.
// ----------------------------------------------------------------------------
module wsp_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_idx,
    input  logic [15:0]   i_cfg_data,
    input  logic          i_empty,
    input  wsp_pkg::t_rec i_rec,
    output logic          o_pop,
    input  logic          i_stall,
    output logic          o_valid,
    output wsp_pkg::t_rec o_orec,
    output logic [6:0]    o_level
);
    import wsp_pkg::*;

    localparam logic [2:0] B_IDLE  = 3'd0;
    localparam logic [2:0] B_DIV1  = 3'd1;
    localparam logic [2:0] B_SCALE = 3'd2;
    localparam logic [2:0] B_DIV2  = 3'd3;
    localparam logic [2:0] B_DONE  = 3'd4;

    logic [15:0]      r_floor, r_full;
    logic [2:0]       r_st;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0] r_scnt, n_scnt, frames;
    t_rec             r_hold, r_orec;
    logic             r_ovalid;
    logic [6:0]       r_olvl;
    logic [QW-1:0]    r_dq;
    logic [DVS_W:0]   r_rem, trial;
    logic [DVS_W-1:0] r_dvs;
    logic [ITER_W-1:0] r_it;
    logic [16:0]      mag;
    logic             out_free, load_out;
    logic [QW-1:0]    diff;
    logic [16:0]      span;

    assign out_free = !r_ovalid || !i_stall;
    assign o_pop    = (r_st == B_IDLE) && !i_empty && out_free;
    assign load_out = (o_pop && !i_rec.lv) || ((r_st == B_DONE) && out_free);

    assign mag    = i_rec.sample[15] ? (17'h10000 - {1'b0, i_rec.sample})
                                     : {1'b0, i_rec.sample};
    assign n_sum  = (i_rec.first ? '0 : r_sum) + (i_rec.acc ? SUM_W'(mag) : '0);
    assign n_scnt = (i_rec.first ? '0 : r_scnt) + CNT_W'(1);
    always_comb begin
        frames = i_rec.stereo ? (n_scnt >> 1) : n_scnt;
        if (frames == '0) frames = CNT_W'(1);
    end

    assign trial = {r_rem[DVS_W-1:0], r_dq[QW-1]};
    assign diff  = r_dq - QW'(r_floor);
    assign span  = {1'b0, r_full} - {1'b0, r_floor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor <= NOISE_RESET;
            r_full  <= FULL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NOISE: r_floor <= i_cfg_data;
                CFG_FULL:  r_full  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // sum and count of the current buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_scnt <= '0;
        end else if (o_pop && i_rec.status == ST_SAMPLE) begin
            r_sum <= n_sum;
            r_scnt <= n_scnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= B_IDLE;
            r_it <= '0;
        end else begin
            unique case (r_st)
                B_IDLE: begin
                    if (o_pop && i_rec.lv) begin
                        r_hold <= i_rec;
                        r_dq <= QW'(n_sum);
                        r_dvs <= DVS_W'(frames);
                        r_rem <= '0;
                        r_it <= '0;
                        r_st <= B_DIV1;
                    end
                end
                B_DIV1, B_DIV2: begin
                    if (trial >= {1'b0, r_dvs}) begin
                        r_rem <= trial - {1'b0, r_dvs};
                        r_dq <= {r_dq[QW-2:0], 1'b1};
                    end else begin
                        r_rem <= trial;
                        r_dq <= {r_dq[QW-2:0], 1'b0};
                    end
                    r_it <= r_it + ITER_W'(1);
                    if (r_it == ITER_W'(QW - 1)) r_st <= (r_st == B_DIV1) ? B_SCALE : B_DONE;
                end
                B_SCALE: begin
                    r_rem <= '0;
                    r_it <= '0;
                    if (r_dq <= QW'(r_floor)) begin
                        r_st <= B_DONE;
                        r_dq <= '0;
                    end else if (diff[QW-1:16] != '0) begin
                        r_st <= B_DONE;
                        r_dq <= QW'(LEVEL_MAX);
                    end else begin
                        r_dq <= QW'(diff[15:0]) * QW'(LEVEL_MAX);
                        r_dvs <= (span[16] || span == '0) ? DVS_W'(1) : span[15:0];
                        r_st <= B_DIV2;
                    end
                end
                B_DONE: begin
                    if (out_free) r_st <= B_IDLE;
                end
                default: r_st <= B_IDLE;
            endcase
        end
    end

    // output stage; clamp the scaled quotient to full scale
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (load_out) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            if (r_st == B_DONE) begin
                r_orec <= r_hold;
                r_olvl <= (r_dq > QW'(LEVEL_MAX)) ? LEVEL_MAX : r_dq[6:0];
            end else begin
                r_orec <= i_rec;
                r_olvl <= '0;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_orec  = r_orec;
    assign o_level = r_olvl;

endmodule

>>> hdl/wav_stream_parser_with_level_meter.sv
// ----------------------------------------------------------------------------
// wav_stream_parser_with_level_meter
// WAV byte stream parser with per-buffer mouth level meter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one stream byte per request;
//   raise i_stream_start with the first header byte to restart parsing.
//   Output channel (o_valid / i_stall) carries one result per sample or
//   per error. Header, chunk headers, fmt body, skipped and low bytes give
//   no result. Config writes (i_cfg_we) set noise floor (index 0) and full
//   scale (index 1); the user must make them only while the block is idle,
//   which the block itself does not enforce. A plain sample passes through
//   the request queue and the output register; a sample that closes a
//   buffer waits in the serial divider computing mean and level. Throughput:
//   one byte per cycle between buffer ends while o_stall is low. While the
//   divider runs, the four-entry request queue fills after about eight more
//   bytes and o_stall then holds the source until the level result leaves.
//   Reset: parser returns to the RIFF header phase, registers to 180/5200.
//   Receiver stall holds the output register, then fills the queue, then
//   raises o_stall toward the byte source.
// ----------------------------------------------------------------------------
module wav_stream_parser_with_level_meter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_stream_byte,
    input  logic        i_stream_start,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic signed [15:0] o_pcm_sample,
    output logic        o_right_channel,
    output logic        o_stereo,
    output logic [31:0] o_sample_rate_hz,
    output logic        o_level_valid,
    output logic [6:0]  o_mouth_level,
    output logic        o_stream_end
);
    import wsp_pkg::*;

    logic take, push, full, empty, pop;
    t_rec frec, qrec, orec;

    // accept a byte whenever the queue has room for its request
    assign o_stall = full;
    assign take    = i_valid && !full;

    wsp_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take),
        .i_stream_byte(i_stream_byte), .i_stream_start(i_stream_start),
        .o_push(push), .o_rec(frec)
    );

    wsp_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_wdata(frec),
        .i_pop(pop), .o_full(full), .o_empty(empty), .o_rdata(qrec)
    );

    wsp_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data), .i_empty(empty),
        .i_rec(qrec), .o_pop(pop), .i_stall(i_stall), .o_valid(o_valid),
        .o_orec(orec), .o_level(o_mouth_level)
    );

    assign o_status         = orec.status;
    assign o_pcm_sample     = orec.sample;
    assign o_right_channel  = orec.right;
    assign o_stereo         = orec.stereo;
    assign o_sample_rate_hz = orec.rate;
    assign o_level_valid    = orec.lv;
    assign o_stream_end     = orec.last;

`ifndef SYNTH
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_mouth_level <= LEVEL_MAX)
        else $error("mouth level above full scale");
    a_level_only_on_lv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_level_valid) |-> o_mouth_level == '0)
        else $error("mouth level without level_valid");
    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_SAMPLE) |-> (o_pcm_sample == '0 && !o_stereo
        && o_sample_rate_hz == '0 && !o_level_valid && !o_stream_end))
        else $error("error result carries sample fields");
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !push)
        else $error("request pushed into full queue");
`endif

endmodule

>>> tb/wav_stream_parser_with_level_meter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wav_stream_parser_with_level_meter_tb
// Drives WAV byte streams (good, malformed and random) into the parser with
// random idling on both sides, predicts every sample, error and level result
// in a behavioral model of the parser and meter, and checks results in order.
// ----------------------------------------------------------------------------
module wav_stream_parser_with_level_meter_tb;
    import wsp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef enum logic [2:0] {
        PH_RIFF, PH_CHDR, PH_FMT, PH_SKIP, PH_PAD, PH_DATA, PH_IDLE
    } t_phase;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] sample;
        logic        right;
        logic        stereo;
        logic [31:0] rate;
        logic        lv;
        logic [6:0]  level;
        logic        last;
    } t_result;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_idx = 1'b0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = '0;
    logic        in_start = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  out_status;
    logic signed [15:0] out_sample;
    logic        out_right, out_stereo, out_lv, out_end;
    logic [31:0] out_rate;
    logic [6:0]  out_level;

    wav_stream_parser_with_level_meter dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_stream_byte(in_byte), .i_stream_start(in_start),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_status(out_status), .o_pcm_sample(out_sample),
        .o_right_channel(out_right), .o_stereo(out_stereo),
        .o_sample_rate_hz(out_rate), .o_level_valid(out_lv),
        .o_mouth_level(out_level), .o_stream_end(out_end)
    );

    always #5 clk = ~clk;

    // Parser state mirrored in the predictor.
    logic [15:0] floor_reg, full_reg;
    t_phase      phase;
    int unsigned fcount, tag, csize, skip_n, fmt_code, chans, rate_hz, bits;
    int unsigned data_n, buf_n, lo_byte, buf_samples;
    longint unsigned amp_sum;
    bit          pad_flag, hdr_bad, odd_pos;

    t_result     expected_q[$];
    int          mismatches = 0;
    bit          idle_en = 1'b1;
    int          idle_cycles = 0;
    bit          timed_out = 1'b0;

    task automatic clear_parser();
        phase = PH_RIFF; fcount = 0; tag = 0; csize = 0; skip_n = 0;
        pad_flag = 0; fmt_code = 0; chans = 0; rate_hz = 0; bits = 0;
        data_n = 0; buf_n = 0; lo_byte = 0; buf_samples = 0; amp_sum = 0;
        hdr_bad = 0; odd_pos = 0;
    endtask

    task automatic push_result(logic [2:0] st, logic [15:0] smp, bit rt, bit lv,
                               logic [6:0] lvl, bit last);
        t_result r;
        bit ok;
        ok = (st == ST_SAMPLE);
        r.status = st;
        r.sample = ok ? smp : 16'd0;
        r.right  = ok && rt;
        r.stereo = ok && (chans == 2);
        r.rate   = ok ? rate_hz : 32'd0;
        r.lv     = lv;
        r.level  = lv ? lvl : 7'd0;
        r.last   = last;
        expected_q.push_back(r);
    endtask

    task automatic raise_error(logic [2:0] st);
        phase = PH_IDLE;
        push_result(st, 16'd0, 0, 0, 7'd0, 0);
    endtask

    task automatic finish_body();
        if (skip_n != 0) phase = PH_SKIP;
        else if (pad_flag) phase = PH_PAD;
        else phase = PH_CHDR;
        fcount = 0;
    endtask

    function automatic logic [6:0] mouth_from_buffer();
        int unsigned frames;
        longint mean, span, lvl;
        frames = buf_samples / (chans != 0 ? chans : 1);
        if (frames == 0) frames = 1;
        mean = longint'(amp_sum / frames);
        span = longint'(full_reg) - longint'(floor_reg);
        if (span < 1) span = 1;
        lvl = ((mean - longint'(floor_reg)) * 100) / span;
        if (lvl < 0) lvl = 0;
        if (lvl > 100) lvl = 100;
        return lvl[6:0];
    endfunction

    task automatic take_data_byte(int unsigned b);
        int unsigned sz, smp, mag;
        bit rt, lv;
        logic [6:0] lvl;
        if (buf_n == 0) begin
            sz = (data_n < BUF_BYTES) ? data_n : BUF_BYTES;
            sz &= ~32'd1;
            if (sz == 0) begin
                raise_error(ST_ODD_BYTE);
                return;
            end
            buf_n = sz; buf_samples = 0; amp_sum = 0;
        end
        data_n--; buf_n--;
        if (buf_n & 1) begin
            lo_byte = b;
            return;
        end
        smp = lo_byte | (b << 8);
        if (buf_samples % chans == 0) begin
            mag = (smp & 16'h8000) ? (32'h10000 - smp) : smp;
            amp_sum += mag;
        end
        buf_samples++;
        rt = (chans == 2) && odd_pos;
        odd_pos = !odd_pos;
        lv = (buf_n == 0);
        lvl = lv ? mouth_from_buffer() : 7'd0;
        if (data_n == 0) phase = PH_IDLE;
        push_result(ST_SAMPLE, smp[15:0], rt, lv, lvl, data_n == 0);
    endtask

    task automatic close_chunk_header();
        pad_flag = csize[0];
        if (tag == TAG_FMT) begin
            if (csize < 16) begin
                raise_error(ST_SHORT_FMT);
                return;
            end
            skip_n = csize - 16; phase = PH_FMT; fcount = 0;
        end else if (tag == TAG_DATA && csize != 0) begin
            if (fmt_code != 1 || bits != 16 || (chans != 1 && chans != 2) || rate_hz == 0)
            begin
                raise_error(ST_BAD_FMT);
                return;
            end
            data_n = csize; buf_n = 0; odd_pos = 0; phase = PH_DATA;
        end else begin
            skip_n = (tag == TAG_DATA) ? 0 : csize;
            finish_body();
        end
    endtask

    // Advance the predictor by one accepted request.
    task automatic predict_byte(logic [7:0] bv, bit start);
        int unsigned b, n;
        b = bv;
        if (start) clear_parser();
        n = fcount;
        case (phase)
            PH_RIFF: begin
                if (n < 4 && b != ((TAG_RIFF >> (8 * n)) & 8'hFF)) hdr_bad = 1;
                if (n >= 8 && b != ((TAG_WAVE >> (8 * (n - 8))) & 8'hFF)) hdr_bad = 1;
                fcount = n + 1;
                if (n == 11) begin
                    if (hdr_bad) raise_error(ST_BAD_RIFF);
                    else begin
                        phase = PH_CHDR; fcount = 0;
                    end
                end
            end
            PH_CHDR: begin
                if (n < 4) begin
                    if (n == 0) tag = 0;
                    tag |= b << (8 * n);
                end else begin
                    if (n == 4) csize = 0;
                    csize |= b << (8 * (n - 4));
                end
                fcount = n + 1;
                if (n == 7) begin
                    fcount = 0;
                    close_chunk_header();
                end
            end
            PH_FMT: begin
                if (n < 2) fmt_code = (fmt_code & ~(32'hFF << (8 * n))) | (b << (8 * n));
                else if (n < 4)
                    chans = (chans & ~(32'hFF << (8 * (n - 2)))) | (b << (8 * (n - 2)));
                else if (n < 8)
                    rate_hz = (rate_hz & ~(32'hFF << (8 * (n - 4)))) | (b << (8 * (n - 4)));
                else if (n >= 14)
                    bits = (bits & ~(32'hFF << (8 * (n - 14)))) | (b << (8 * (n - 14)));
                fcount = n + 1;
                if (n == 15) finish_body();
            end
            PH_SKIP: begin
                skip_n--;
                if (skip_n == 0) finish_body();
            end
            PH_PAD: begin
                pad_flag = 0; phase = PH_CHDR; fcount = 0;
            end
            PH_DATA: take_data_byte(b);
            default: ;
        endcase
    endtask

    // Send one request, idling beforehand at random; hold it until accepted.
    // Valid stays high afterwards so back-to-back requests need no gap.
    task automatic send_byte(logic [7:0] b, bit start = 0);
        if (idle_en && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        in_valid <= 1'b1; in_byte <= b; in_start <= start;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_byte(b, start);
        @(negedge clk);
    endtask

    task automatic send_u16(int unsigned v);
        send_byte(v[7:0]); send_byte(v[15:8]);
    endtask

    task automatic send_u32(int unsigned v);
        send_u16(v[15:0]); send_u16(v[31:16]);
    endtask

    task automatic send_header();
        send_byte(8'h52, 1); send_byte(8'h49); send_byte(8'h46); send_byte(8'h46);
        send_u32($urandom);
        send_u32(TAG_WAVE);
    endtask

    task automatic send_fmt(int unsigned size, int unsigned code, int unsigned ch,
                            int unsigned rate, int unsigned bw);
        send_u32(TAG_FMT); send_u32(size);
        send_u16(code); send_u16(ch); send_u32(rate);
        send_u32($urandom); send_u16($urandom);
        send_u16(bw);
        repeat (size - 16) send_byte(8'($urandom));
        if (size[0]) send_byte(8'($urandom));
    endtask

    // Send a data chunk header plus payload; samples lean on extremes.
    task automatic send_data(int unsigned size, int unsigned sent);
        send_u32(TAG_DATA); send_u32(size);
        for (int i = 0; i < sent; i++) begin
            case ($urandom_range(0, 5))
                0: send_byte(8'h00);
                1: send_byte(8'hFF);
                2: send_byte(8'h80);
                3: send_byte(8'h7F);
                default: send_byte(8'($urandom));
            endcase
        end
    endtask

    task automatic write_reg(logic idx, logic [15:0] v);
        @(negedge clk);
        cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_NOISE) floor_reg = v;
        else full_reg = v;
    endtask

    // Drop valid, drain results, then let the divider settle before a register write.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    // Check each accepted result against the oldest expectation.
    always @(posedge clk) begin
        t_result act, exp_r;
        if (rst_n && out_valid && !out_stall) begin
            act = '{out_status, out_sample, out_right, out_stereo, out_rate,
                    out_lv, out_level, out_end};
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", act);
            end else begin
                exp_r = expected_q.pop_front();
                if (act !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch exp %p got %p", exp_r, act);
                end
            end
        end
    end

    // Receiver stalls in random bursts.
    initial begin
        forever begin
            @(negedge clk);
            if (idle_en && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    // Watchdog: count cycles with no accepted request on either side.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("wav_stream_parser_with_level_meter_tb NOT OK");
            $finish;
        end
    end

    task automatic test_errors();
        // Bad RIFF header.
        send_byte(8'h52, 1); repeat (11) send_byte(8'($urandom));
        // Short fmt chunk.
        send_header(); send_u32(TAG_FMT); send_u32(15);
        // Unsupported format: 8-bit PCM.
        send_header(); send_fmt(16, 1, 1, 8000, 8); send_data(4, 0);
        // Unsupported format: no fmt at all, zero rate.
        send_header(); send_data(2, 0);
        // Trailing odd byte, then ignored bytes.
        send_header(); send_fmt(16, 1, 2, 1, 16); send_data(5, 5);
        repeat (3) send_byte(8'($urandom));
    endtask

    task automatic test_chunks();
        // Extension, unknown chunk with odd pad, empty data chunk, then data.
        send_header();
        send_fmt(19, 1, 2, 44100, 16);
        send_u32(32'h5453_494C); send_u32(3); repeat (4) send_byte(8'($urandom));
        send_u32(TAG_DATA); send_u32(0);
        send_data(8, 8);
    endtask

    task automatic test_registers();
        wait_drained();
        write_reg(CFG_NOISE, 16'd0); write_reg(CFG_FULL, 16'd32768);
        send_header(); send_fmt(16, 1, 1, 16000, 16); send_data(40, 40);
        wait_drained();
        write_reg(CFG_NOISE, 16'd32768); write_reg(CFG_FULL, 16'd0);
        send_header(); send_fmt(16, 1, 2, 8000, 16); send_data(12, 12);
        wait_drained();
        write_reg(CFG_NOISE, 16'hFFFF); write_reg(CFG_FULL, 16'hFFFF);
        send_header(); send_fmt(16, 1, 1, 8000, 16); send_data(4, 4);
        wait_drained();
        write_reg(CFG_NOISE, 16'd100); write_reg(CFG_FULL, 16'd20000);
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 250) begin
            case ($urandom_range(0, 9))
                0: begin
                    repeat (12) send_byte(8'($urandom), $urandom_range(0, 3) == 0);
                    sent += 12;
                end
                1: begin
                    send_header(); send_fmt($urandom_range(16, 20), $urandom_range(0, 2),
                        $urandom_range(0, 3), $urandom_range(0, 2) * 22050, 16);
                    send_data($urandom_range(1, 20), $urandom_range(0, 10));
                    sent += 40;
                end
                default: begin
                    int unsigned n;
                    n = $urandom_range(1, 60);
                    send_header();
                    send_fmt(16, 1, $urandom_range(1, 2), $urandom, 16);
                    send_data(n, n);
                    sent += 36 + n;
                end
            endcase
            if (sent > 180) idle_en = 1'b0;
        end
    endtask

    initial begin
        floor_reg = NOISE_RESET; full_reg = FULL_RESET;
        clear_parser();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_errors();
        test_chunks();
        wait_drained();   // sender pause until all results have come
        test_registers();
        test_random();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("wav_stream_parser_with_level_meter_tb OK");
        else
            $display("wav_stream_parser_with_level_meter_tb NOT OK");
        $finish;
    end
endmodule
